[rtl/cht_pkg.sv]
// cht_pkg: types, codes and byte-class helpers for the cookie header tokenizer
// used by cht_step and cookie_header_tokenizer; depends on nothing else
package cht_pkg;

    typedef enum logic [3:0] {
        PH_IDLE = 4'd0,
        PH_NAME = 4'd1,
        PH_EQ   = 4'd2,
        PH_V0   = 4'd3,
        PH_V    = 4'd4,
        PH_VH1  = 4'd5,
        PH_VH2  = 4'd6,
        PH_VE   = 4'd7,
        PH_Q    = 4'd8,
        PH_QH1  = 4'd9,
        PH_QH2  = 4'd10,
        PH_QE   = 4'd11
    } t_phase;

    typedef enum logic [2:0] {
        K_NAME = 3'd0,
        K_VAL  = 3'd1,
        K_END  = 3'd2,
        K_ERR  = 3'd3,
        K_DONE = 3'd4
    } t_kind;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_EOH  = 1'b1;

    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_EQUALS  = 8'h3D;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [2:0] SECURE_LEN = 3'd6;

    localparam int unsigned MAX_RES = 3;

    typedef struct packed {
        logic       op;
        logic [7:0] char_in;
    } t_in;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data_byte;
        logic       is_attribute;
        logic       is_secure;
        logic       last;
    } t_out;

    typedef struct packed {
        t_phase     parse_phase;
        logic [7:0] held_hex_digit;
        logic       attribute_flag;
        logic [2:0] secure_match_progress;
        logic       secure_mismatch;
        logic       halted_on_error;
    } t_state;

    // results caused by one item, in order, plus how many are meaningful
    typedef struct packed {
        t_out [MAX_RES-1:0] res;
        logic [1:0]         cnt;
    } t_bundle;

    localparam t_state STATE_RESET = '{
        parse_phase:           PH_IDLE,
        held_hex_digit:        8'd0,
        attribute_flag:        1'b0,
        secure_match_progress: 3'd0,
        secure_mismatch:       1'b0,
        halted_on_error:       1'b0
    };

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if (c >= "0" && c <= "9") begin
            v = c - 8'h30;
        end else if (c >= "A" && c <= "F") begin
            v = c - 8'h37;
        end else if (c >= "a" && c <= "f") begin
            v = c - 8'h57;
        end
        return v[3:0];
    endfunction

    function automatic logic [7:0] plus_to_space(input logic [7:0] c);
        return (c == CH_PLUS) ? CH_SPACE : c;
    endfunction

    function automatic logic [7:0] secure_char(input logic [2:0] i);
        logic [7:0] ch;
        unique case (i)
            3'd0:    ch = "S";
            3'd1:    ch = "e";
            3'd2:    ch = "c";
            3'd3:    ch = "u";
            3'd4:    ch = "r";
            3'd5:    ch = "e";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic t_out mk(input t_kind k, input logic [7:0] d, input logic at,
                                input logic sec);
        t_out r;
        r.kind         = k;
        r.data_byte    = d;
        r.is_attribute = at;
        r.is_secure    = sec;
        r.last         = 1'b0;
        return r;
    endfunction

endpackage

[rtl/cht_step.sv]
// cht_step: one tokenizer step, next state and the results caused by one item
// depends on cht_pkg
module cht_step (
    input  cht_pkg::t_state  i_state,
    input  cht_pkg::t_in     i_item,
    output cht_pkg::t_state  o_state,
    output cht_pkg::t_bundle o_bundle
);

    logic            name_sec;
    logic [7:0]      c;
    logic [7:0]      h;
    logic            q;
    cht_pkg::t_out   end_res;
    cht_pkg::t_out   err_res;
    cht_pkg::t_out   nul_res;

    assign c        = i_item.char_in;
    assign h        = i_state.held_hex_digit;
    assign name_sec = !i_state.secure_mismatch
                      && (i_state.secure_match_progress == cht_pkg::SECURE_LEN);
    assign end_res  = cht_pkg::mk(cht_pkg::K_END, 8'd0, i_state.attribute_flag,
                                  i_state.attribute_flag && name_sec);
    assign err_res  = cht_pkg::mk(cht_pkg::K_ERR, 8'd0, 1'b0, 1'b0);
    assign nul_res  = cht_pkg::mk(cht_pkg::K_NAME, 8'd0, 1'b0, 1'b0);
    assign q        = (i_state.parse_phase == cht_pkg::PH_Q)
                      || (i_state.parse_phase == cht_pkg::PH_QH1)
                      || (i_state.parse_phase == cht_pkg::PH_QH2);

    always_comb begin
        o_state         = i_state;
        o_bundle.cnt    = 2'd0;
        o_bundle.res[0] = nul_res;
        o_bundle.res[1] = nul_res;
        o_bundle.res[2] = nul_res;

        if (i_item.op == cht_pkg::OP_EOH) begin
            o_state = cht_pkg::STATE_RESET;
            o_bundle.res[0] = cht_pkg::mk(cht_pkg::K_DONE, 8'd0, 1'b0, 1'b0);
            o_bundle.cnt    = 2'd1;
            // codes outside the phase list count as idle here too
            if (!i_state.halted_on_error && i_state.parse_phase != cht_pkg::PH_IDLE
                    && i_state.parse_phase <= cht_pkg::PH_QE) begin
                o_bundle.res[1] = o_bundle.res[0];
                o_bundle.cnt    = 2'd2;
                if (i_state.parse_phase == cht_pkg::PH_QE
                        || i_state.parse_phase == cht_pkg::PH_V
                        || i_state.parse_phase == cht_pkg::PH_V0) begin
                    o_bundle.res[0] = end_res;
                end else begin
                    o_bundle.res[0] = err_res;
                end
            end
        end else if (!i_state.halted_on_error) begin
            unique case (i_state.parse_phase)
                cht_pkg::PH_NAME: begin
                    if (cht_pkg::is_space(c)) begin
                        o_state.parse_phase = name_sec ? cht_pkg::PH_VE : cht_pkg::PH_EQ;
                    end else if (c == cht_pkg::CH_EQUALS) begin
                        o_state.parse_phase = name_sec ? cht_pkg::PH_VE : cht_pkg::PH_V0;
                    end else if (c == cht_pkg::CH_SEMI && name_sec) begin
                        o_state.parse_phase = cht_pkg::PH_VE;
                    end else begin
                        if (i_state.secure_mismatch
                                || i_state.secure_match_progress >= cht_pkg::SECURE_LEN
                                || c != cht_pkg::secure_char(i_state.secure_match_progress)) begin
                            o_state.secure_mismatch = 1'b1;
                        end else begin
                            o_state.secure_match_progress = i_state.secure_match_progress + 3'd1;
                        end
                        o_bundle.res[0] = cht_pkg::mk(cht_pkg::K_NAME, c, 1'b0, 1'b0);
                        o_bundle.cnt    = 2'd1;
                    end
                end
                cht_pkg::PH_EQ: begin
                    if (c == cht_pkg::CH_EQUALS) begin
                        o_state.parse_phase = cht_pkg::PH_V0;
                    end else if (!cht_pkg::is_space(c)) begin
                        o_state.halted_on_error = 1'b1;
                        o_bundle.res[0] = err_res;
                        o_bundle.cnt    = 2'd1;
                    end
                end
                cht_pkg::PH_V0: begin
                    if (c == cht_pkg::CH_QUOTE) begin
                        o_state.parse_phase = cht_pkg::PH_Q;
                    end else if (c == cht_pkg::CH_PERCENT) begin
                        o_state.parse_phase = cht_pkg::PH_VH1;
                    end else if (c == cht_pkg::CH_SEMI) begin
                        o_state.parse_phase = cht_pkg::PH_IDLE;
                        o_bundle.res[0] = end_res;
                        o_bundle.cnt    = 2'd1;
                    end else if (!cht_pkg::is_space(c)) begin
                        o_state.parse_phase = cht_pkg::PH_V;
                        o_bundle.res[0] = cht_pkg::mk(cht_pkg::K_VAL, c, 1'b0, 1'b0);
                        o_bundle.cnt    = 2'd1;
                    end
                end
                cht_pkg::PH_V, cht_pkg::PH_Q: begin
                    if (!q && c == cht_pkg::CH_SEMI) begin
                        o_state.parse_phase = cht_pkg::PH_IDLE;
                        o_bundle.res[0] = end_res;
                        o_bundle.cnt    = 2'd1;
                    end else if (q && c == cht_pkg::CH_QUOTE) begin
                        o_state.parse_phase = cht_pkg::PH_QE;
                    end else if (c == cht_pkg::CH_PERCENT) begin
                        o_state.parse_phase = q ? cht_pkg::PH_QH1 : cht_pkg::PH_VH1;
                    end else begin
                        o_bundle.res[0] = cht_pkg::mk(cht_pkg::K_VAL,
                                                      cht_pkg::plus_to_space(c), 1'b0, 1'b0);
                        o_bundle.cnt    = 2'd1;
                    end
                end
                cht_pkg::PH_VH1, cht_pkg::PH_QH1: begin
                    if (cht_pkg::is_hex(c)) begin
                        o_state.held_hex_digit = c;
                        o_state.parse_phase    = q ? cht_pkg::PH_QH2 : cht_pkg::PH_VH2;
                    end else if ((!q && c == cht_pkg::CH_SEMI)
                                 || (q && c == cht_pkg::CH_QUOTE)) begin
                        // broken escape at the value end: keep the percent sign
                        o_bundle.res[0] = cht_pkg::mk(cht_pkg::K_VAL, cht_pkg::CH_PERCENT,
                                                      1'b0, 1'b0);
                        if (q) begin
                            o_state.parse_phase = cht_pkg::PH_QE;
                            o_bundle.cnt        = 2'd1;
                        end else begin
                            o_state.parse_phase = cht_pkg::PH_IDLE;
                            o_bundle.res[1]     = end_res;
                            o_bundle.cnt        = 2'd2;
                        end
                    end else begin
                        o_state.parse_phase = q ? cht_pkg::PH_Q : cht_pkg::PH_V;
                        o_bundle.res[0] = cht_pkg::mk(cht_pkg::K_VAL, cht_pkg::CH_PERCENT,
                                                      1'b0, 1'b0);
                        o_bundle.res[1] = cht_pkg::mk(cht_pkg::K_VAL,
                                                      cht_pkg::plus_to_space(c), 1'b0, 1'b0);
                        o_bundle.cnt    = 2'd2;
                    end
                end
                cht_pkg::PH_VH2, cht_pkg::PH_QH2: begin
                    if (cht_pkg::is_hex(c)) begin
                        o_state.parse_phase = q ? cht_pkg::PH_Q : cht_pkg::PH_V;
                        o_bundle.res[0] = cht_pkg::mk(cht_pkg::K_VAL,
                                                      {cht_pkg::hex_val(h), cht_pkg::hex_val(c)},
                                                      1'b0, 1'b0);
                        o_bundle.cnt    = 2'd1;
                    end else if ((!q && c == cht_pkg::CH_SEMI)
                                 || (q && c == cht_pkg::CH_QUOTE)) begin
                        o_bundle.res[0] = cht_pkg::mk(cht_pkg::K_VAL, cht_pkg::CH_PERCENT,
                                                      1'b0, 1'b0);
                        o_bundle.res[1] = cht_pkg::mk(cht_pkg::K_VAL, h, 1'b0, 1'b0);
                        if (q) begin
                            o_state.parse_phase = cht_pkg::PH_QE;
                            o_bundle.cnt        = 2'd2;
                        end else begin
                            o_state.parse_phase = cht_pkg::PH_IDLE;
                            o_bundle.res[2]     = end_res;
                            o_bundle.cnt        = 2'd3;
                        end
                    end else begin
                        // single digit escape: emit the digit value, then the byte
                        o_state.parse_phase = q ? cht_pkg::PH_Q : cht_pkg::PH_V;
                        o_bundle.res[0] = cht_pkg::mk(cht_pkg::K_VAL,
                                                      {4'd0, cht_pkg::hex_val(h)}, 1'b0, 1'b0);
                        o_bundle.res[1] = cht_pkg::mk(cht_pkg::K_VAL,
                                                      cht_pkg::plus_to_space(c), 1'b0, 1'b0);
                        o_bundle.cnt    = 2'd2;
                    end
                end
                cht_pkg::PH_VE: begin
                    if (c == cht_pkg::CH_SEMI) begin
                        o_state.parse_phase = cht_pkg::PH_IDLE;
                        o_bundle.res[0] = end_res;
                        o_bundle.cnt    = 2'd1;
                    end else if (c == cht_pkg::CH_PLUS) begin
                        o_bundle.res[0] = cht_pkg::mk(cht_pkg::K_VAL, cht_pkg::CH_SPACE,
                                                      1'b0, 1'b0);
                        o_bundle.cnt    = 2'd1;
                    end else if (!cht_pkg::is_space(c)) begin
                        o_state.halted_on_error = 1'b1;
                        o_bundle.res[0] = err_res;
                        o_bundle.cnt    = 2'd1;
                    end
                end
                cht_pkg::PH_QE: begin
                    if (c == cht_pkg::CH_SEMI) begin
                        o_state.parse_phase = cht_pkg::PH_IDLE;
                        o_bundle.res[0] = end_res;
                        o_bundle.cnt    = 2'd1;
                    end else if (!cht_pkg::is_space(c)) begin
                        o_state.halted_on_error = 1'b1;
                        o_bundle.res[0] = err_res;
                        o_bundle.cnt    = 2'd1;
                    end
                end
                default: begin
                    // idle between pairs, also any code outside the phase list
                    o_state.secure_match_progress = 3'd0;
                    o_state.secure_mismatch       = 1'b0;
                    if (c == cht_pkg::CH_DOLLAR) begin
                        o_state.attribute_flag = 1'b1;
                        o_state.parse_phase    = cht_pkg::PH_NAME;
                    end else if (!cht_pkg::is_space(c)) begin
                        o_state.attribute_flag = 1'b0;
                        if (c == cht_pkg::secure_char(3'd0)) begin
                            o_state.secure_match_progress = 3'd1;
                        end else begin
                            o_state.secure_mismatch = 1'b1;
                        end
                        o_state.parse_phase = cht_pkg::PH_NAME;
                        o_bundle.res[0] = cht_pkg::mk(cht_pkg::K_NAME, c, 1'b0, 1'b0);
                        o_bundle.cnt    = 2'd1;
                    end else begin
                        o_state.parse_phase = cht_pkg::PH_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

[rtl/cookie_header_tokenizer.sv]
// cookie_header_tokenizer: the first result shows in the cycle after the input transfer
// an item is taken every cycle while the output is ready and each gives at most one
// result; an item with n results (up to three) holds the input while its results drain
// synchronous active-low reset returns the tokenizer to idle and empties the results
// depends on cht_pkg and cht_step
module cookie_header_tokenizer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  cht_pkg::t_in    i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output cht_pkg::t_out   o_out_data
);

    cht_pkg::t_state  r_state;
    cht_pkg::t_state  n_state;
    cht_pkg::t_bundle n_bundle;
    cht_pkg::t_out    r_res [cht_pkg::MAX_RES];
    logic [1:0]       r_cnt;
    logic [1:0]       r_idx;
    logic             in_xfer;
    logic             out_xfer;
    logic             final_out;
    cht_pkg::t_out    sel;

    cht_step u_step (
        .i_state  (r_state),
        .i_item   (i_in_data),
        .o_state  (n_state),
        .o_bundle (n_bundle)
    );

    assign o_out_valid = (r_idx != r_cnt);
    assign final_out   = (r_idx == r_cnt - 2'd1);
    assign out_xfer    = o_out_valid && i_out_ready;
    // the result register frees up in the same cycle its last result leaves
    assign o_in_ready  = !o_out_valid || (out_xfer && final_out);
    assign in_xfer     = i_in_valid && o_in_ready;

    always_comb begin
        unique case (r_idx)
            2'd1:    sel = r_res[1];
            2'd2:    sel = r_res[2];
            default: sel = r_res[0];
        endcase
        o_out_data      = sel;
        o_out_data.last = final_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cht_pkg::STATE_RESET;
            r_cnt   <= 2'd0;
            r_idx   <= 2'd0;
        end else if (in_xfer) begin
            r_state <= n_state;
            r_cnt   <= n_bundle.cnt;
            r_idx   <= 2'd0;
        end else if (out_xfer) begin
            r_idx   <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_res[0] <= n_bundle.res[0];
            r_res[1] <= n_bundle.res[1];
            r_res[2] <= n_bundle.res[2];
        end
    end

endmodule
